// ----- design/rpr_pkg.sv -----
package rpr_pkg;

    localparam int unsigned MAX_WAYPOINTS_DEF = 64;
    localparam int unsigned DIST_W  = 20;
    localparam int unsigned ALT_W   = 17;
    localparam int unsigned CNT_W   = 12;
    localparam int unsigned OP_W    = 2;
    localparam logic [CNT_W-1:0] SAMPLE_COUNT_RST = 12'd200;

    // divider operand widths
    localparam int unsigned DVD_W = 52;
    localparam int unsigned DVS_W = 34;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_RDLAST, S_TARGET, S_DIV0, S_DIV0W, S_SDIST,
        S_RDSEG, S_BMUL, S_CMP, S_RDA, S_AMUL, S_DECIDE,
        S_NUM, S_MULN, S_FIX, S_DIV1, S_DIV1W, S_FIN, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_IN, CMD_RDLAST, CMD_TARGET, CMD_DIV0, CMD_SDIST,
        CMD_RDSEG, CMD_BMUL, CMD_CMP, CMD_RDA, CMD_AMUL, CMD_DECIDE,
        CMD_NUM, CMD_MULN, CMD_FIX, CMD_DIV1, CMD_FIN, CMD_LOAD
    } t_cmd_code;

    typedef struct packed {
        t_cmd_code code;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            cnt_lt2;
        logic            div_done;
        logic            found;
        logic            seg_last;
        logic            a_eq_b;
        logic            out_free;
    } t_sts;

endpackage

// ----- design/rpr_div.sv -----
module rpr_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rpr_pkg::DVD_W-1:0] i_dividend,
    input  logic [rpr_pkg::DVS_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [rpr_pkg::DVD_W-1:0] o_quo,
    output logic [rpr_pkg::DVS_W-1:0] o_rem
);
    import rpr_pkg::*;

    localparam int unsigned IT_W = $clog2(DVD_W);

    logic             r_busy, n_busy;
    logic [IT_W-1:0]  r_it, n_it;
    logic [DVD_W-1:0] r_quo, n_quo;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs, n_dvs;
    logic [DVS_W:0]   rem_sh;

    // restoring division, one quotient bit per cycle
    always_comb begin
        n_busy = r_busy;
        n_it   = r_it;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        rem_sh = {r_rem, r_quo[DVD_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_it   = IT_W'(DVD_W - 1);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_dvs}) begin
                n_rem = DVS_W'(rem_sh - {1'b0, r_dvs});
                n_quo = {r_quo[DVD_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[DVS_W-1:0];
                n_quo = {r_quo[DVD_W-2:0], 1'b0};
            end
            n_it = r_it - 1'b1;
            if (r_it == '0) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_it   <= '0;
        end else begin
            r_busy <= n_busy;
            r_it   <= n_it;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done = r_busy && (r_it == '0);
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ----- design/rpr_ctrl.sv -----
module rpr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  rpr_pkg::t_sts i_sts,
    output rpr_pkg::t_cmd o_cmd
);
    import rpr_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and command
    always_comb begin
        n_state    = r_state;
        o_cmd.code = CMD_NONE;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.code = CMD_IN;
                    if (i_sts.op == OP_QUERY) begin
                        n_state = i_sts.cnt_lt2 ? S_DONE : S_RDLAST;
                    end
                end
            end
            S_RDLAST: begin
                o_cmd.code = CMD_RDLAST;
                n_state = S_TARGET;
            end
            S_TARGET: begin
                o_cmd.code = CMD_TARGET;
                n_state = S_DIV0;
            end
            S_DIV0: begin
                o_cmd.code = CMD_DIV0;
                n_state = S_DIV0W;
            end
            S_DIV0W: begin
                if (i_sts.div_done) begin
                    n_state = S_SDIST;
                end
            end
            S_SDIST: begin
                o_cmd.code = CMD_SDIST;
                n_state = S_RDSEG;
            end
            S_RDSEG: begin
                o_cmd.code = CMD_RDSEG;
                n_state = S_BMUL;
            end
            S_BMUL: begin
                o_cmd.code = CMD_BMUL;
                n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.code = CMD_CMP;
                if (i_sts.found) begin
                    n_state = S_RDA;
                end else if (i_sts.seg_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RDSEG;
                end
            end
            S_RDA: begin
                o_cmd.code = CMD_RDA;
                n_state = S_AMUL;
            end
            S_AMUL: begin
                o_cmd.code = CMD_AMUL;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.code = CMD_DECIDE;
                n_state = i_sts.a_eq_b ? S_DONE : S_NUM;
            end
            S_NUM: begin
                o_cmd.code = CMD_NUM;
                n_state = S_MULN;
            end
            S_MULN: begin
                o_cmd.code = CMD_MULN;
                n_state = S_FIX;
            end
            S_FIX: begin
                o_cmd.code = CMD_FIX;
                n_state = S_DIV1;
            end
            S_DIV1: begin
                o_cmd.code = CMD_DIV1;
                n_state = S_DIV1W;
            end
            S_DIV1W: begin
                if (i_sts.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.code = CMD_FIN;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.code = CMD_LOAD;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- design/rpr_dp.sv -----
module rpr_dp #(
    parameter int unsigned MAX_WAYPOINTS = rpr_pkg::MAX_WAYPOINTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rpr_pkg::t_cmd                    i_cmd,
    output rpr_pkg::t_sts                    o_sts,
    input  logic                             i_cfg_we,
    input  logic [rpr_pkg::CNT_W-1:0]        i_cfg_data,
    input  logic [rpr_pkg::OP_W-1:0]         i_op,
    input  logic [rpr_pkg::DIST_W-1:0]       i_wp_distance,
    input  logic signed [rpr_pkg::ALT_W-1:0] i_wp_altitude,
    input  logic [rpr_pkg::CNT_W-1:0]        i_sample_index,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [rpr_pkg::DIST_W-1:0]       o_sample_distance,
    output logic signed [rpr_pkg::ALT_W-1:0] o_sample_altitude,
    output logic                             o_profile_valid,
    output logic                             o_route_overflow
);
    import rpr_pkg::*;

    localparam int unsigned AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
    localparam int unsigned CW = $clog2(MAX_WAYPOINTS + 1);
    localparam int unsigned PW = DIST_W + CNT_W;

    // waypoint stores
    logic [DIST_W-1:0]       mem_d [MAX_WAYPOINTS];
    logic signed [ALT_W-1:0] mem_y [MAX_WAYPOINTS];
    logic [DIST_W-1:0]       r_rd_d;
    logic signed [ALT_W-1:0] r_rd_y;
    logic [AW-1:0]           rd_addr;
    logic                    rd_en;
    logic                    wr_en;

    logic [CNT_W-1:0] r_sc;
    logic [CNT_W-1:0] n_eff;
    logic [CW-1:0]    r_cnt;
    logic             r_ovf;
    logic [CNT_W-1:0] r_idx;
    logic [AW-1:0]    r_seg;
    logic [CW-1:0]    cnt_m1;

    logic [PW-1:0]           r_target;
    logic [PW-1:0]           r_prod;
    logic [DIST_W-1:0]       r_b;
    logic signed [ALT_W-1:0] r_yb, r_ya, r_last_y;
    logic                    r_aeqb;
    logic [PW-1:0]           r_an;
    logic signed [DIST_W:0]  r_dba;
    logic signed [PW:0]      r_tdiff;
    logic signed [PW+1:0]    r_den;
    logic signed [ALT_W:0]   r_dy;
    logic signed [ALT_W+PW+1:0] r_num;
    logic [PW:0]             r_den_abs;
    logic signed [DVD_W:0]   r_x;

    // result registers
    logic [DIST_W-1:0]       r_sdist;
    logic signed [ALT_W-1:0] r_alt;
    logic                    r_pv;

    // output register
    logic                    r_ov;
    logic [DIST_W-1:0]       r_o_dist;
    logic signed [ALT_W-1:0] r_o_alt;
    logic                    r_o_pv, r_o_ovf;

    // divider hookup
    logic             div_start, div_done;
    logic [DVD_W-1:0] div_dvd, div_quo;
    logic [DVS_W-1:0] div_dvs, div_rem;
    logic [DVD_W-1:0] x_abs;

    // final rounding and saturation
    logic signed [DVD_W+1:0] q_s, alt_w;
    logic signed [ALT_W:0]   nxt_dy;
    logic signed [ALT_W+PW+1:0] num_f;
    logic signed [DVD_W:0]   x_nxt;

    assign n_eff  = (r_sc == '0) ? CNT_W'(1) : r_sc;
    assign cnt_m1 = r_cnt - 1'b1;
    assign x_abs  = r_x[DVD_W] ? DVD_W'(-r_x) : r_x[DVD_W-1:0];

    always_comb begin
        rd_en   = 1'b1;
        rd_addr = r_seg;
        case (i_cmd.code)
            CMD_RDLAST: rd_addr = cnt_m1[AW-1:0];
            CMD_RDSEG:  rd_addr = r_seg;
            CMD_RDA:    rd_addr = AW'(r_seg - 1'b1);
            default:    rd_en   = 1'b0;
        endcase
    end

    assign wr_en = (i_cmd.code == CMD_IN) && (i_op == OP_APPEND) &&
                   (r_cnt < CW'(MAX_WAYPOINTS));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_d[r_cnt[AW-1:0]] <= i_wp_distance;
            mem_y[r_cnt[AW-1:0]] <= i_wp_altitude;
        end
        if (rd_en) begin
            r_rd_d <= mem_d[rd_addr];
            r_rd_y <= mem_y[rd_addr];
        end
    end

    // divider operands
    always_comb begin
        div_start = 1'b0;
        div_dvd   = {(DVD_W-PW)'(0), r_target};
        div_dvs   = {(DVS_W-CNT_W)'(0), n_eff};
        case (i_cmd.code)
            CMD_DIV0: div_start = 1'b1;
            CMD_DIV1: begin
                div_start = 1'b1;
                div_dvd   = x_abs;
                div_dvs   = {r_den_abs, 1'b0};
            end
            default: div_start = 1'b0;
        endcase
    end

    rpr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // combinational helpers
    always_comb begin
        nxt_dy = $signed({r_yb[ALT_W-1], r_yb}) - $signed({r_rd_y[ALT_W-1], r_rd_y});
        num_f  = r_den[PW+1] ? -r_num : r_num;
        x_nxt  = $signed({num_f, 1'b0}) + $signed({1'b0, r_den_abs});
        if (r_x[DVD_W]) begin
            q_s = -$signed({2'b00, div_quo}) - $signed({(DVD_W+1)'(0), (div_rem != '0)});
        end else begin
            q_s = $signed({2'b00, div_quo});
        end
        alt_w = q_s + (DVD_W+2)'(r_ya);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc  <= SAMPLE_COUNT_RST;
            r_cnt <= '0;
            r_ovf <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_sc <= i_cfg_data;
            end
            if (i_cmd.code == CMD_IN) begin
                if (i_op == OP_CLEAR) begin
                    r_cnt <= '0;
                    r_ovf <= 1'b0;
                end else if (i_op == OP_APPEND) begin
                    if (wr_en) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
            end
            if (i_cmd.code == CMD_LOAD) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.code)
            CMD_IN: begin
                r_idx   <= (i_sample_index > n_eff) ? n_eff : i_sample_index;
                r_pv    <= (r_cnt >= CW'(2));
                r_sdist <= '0;
                r_alt   <= '0;
                r_seg   <= AW'(1);
            end
            CMD_TARGET: begin
                r_target <= PW'(r_rd_d) * PW'(r_idx);
                r_last_y <= r_rd_y;
            end
            CMD_SDIST: r_sdist <= div_quo[DIST_W-1:0];
            CMD_BMUL: begin
                r_b    <= r_rd_d;
                r_yb   <= r_rd_y;
                r_prod <= PW'(r_rd_d) * PW'(n_eff);
            end
            CMD_CMP: begin
                if (r_prod < r_target) begin
                    if ({1'b0, r_seg} == cnt_m1) begin
                        r_alt <= r_last_y;
                    end else begin
                        r_seg <= r_seg + 1'b1;
                    end
                end
            end
            CMD_AMUL: begin
                r_ya   <= r_rd_y;
                r_aeqb <= (r_rd_d == r_b);
                r_an   <= PW'(r_rd_d) * PW'(n_eff);
                r_dba  <= $signed({1'b0, r_b}) - $signed({1'b0, r_rd_d});
                r_dy   <= nxt_dy;
            end
            CMD_DECIDE: begin
                if (r_aeqb) begin
                    r_alt <= r_yb;
                end
            end
            CMD_NUM: begin
                r_tdiff <= $signed({1'b0, r_target}) - $signed({1'b0, r_an});
                r_den   <= (PW+2)'(r_dba) * (PW+2)'($signed({1'b0, n_eff}));
            end
            CMD_MULN: begin
                r_num     <= (ALT_W+PW+2)'(r_dy) * (ALT_W+PW+2)'(r_tdiff);
                r_den_abs <= r_den[PW+1] ? (PW+1)'(-r_den) : r_den[PW:0];
            end
            CMD_FIX: r_x <= x_nxt;
            CMD_FIN: begin
                if (alt_w < -(DVD_W+2)'(65536)) begin
                    r_alt <= ALT_W'(-65536);
                end else if (alt_w > (DVD_W+2)'(65535)) begin
                    r_alt <= ALT_W'(65535);
                end else begin
                    r_alt <= alt_w[ALT_W-1:0];
                end
            end
            CMD_LOAD: begin
                r_o_dist <= r_sdist;
                r_o_alt  <= r_alt;
                r_o_pv   <= r_pv;
                r_o_ovf  <= r_ovf;
            end
            default: r_seg <= r_seg;
        endcase
    end

    assign o_sts.op       = i_op;
    assign o_sts.cnt_lt2  = (r_cnt < CW'(2));
    assign o_sts.div_done = div_done;
    assign o_sts.found    = (r_prod >= r_target);
    assign o_sts.seg_last = ({1'b0, r_seg} == cnt_m1);
    assign o_sts.a_eq_b   = r_aeqb;
    assign o_sts.out_free = !r_ov || !i_out_stall;

    assign o_out_valid       = r_ov;
    assign o_sample_distance = r_o_dist;
    assign o_sample_altitude = r_o_alt;
    assign o_profile_valid   = r_o_pv;
    assign o_route_overflow  = r_o_ovf;

endmodule

// ----- design/route_profile_resampler.sv -----
// Route profile resampler: holds up to MAX_WAYPOINTS (distance, altitude)
// waypoints and answers sample queries by linear interpolation along the route.
// Clear and append transactions complete in the idle state. A query with fewer
// than two waypoints goes straight to the output stage; otherwise the time from
// acceptance to the output register load grows with k, the number of segments
// walked (one registered store read and one multiply per segment), and most of
// the rest is two passes of the shared one-bit-per-cycle divider. A point past
// the end or on a zero-length segment skips the second division and finishes
// sooner. One item is worked at a time; the result sits in an output register,
// so new transactions are taken while it waits.
module route_profile_resampler #(
    parameter int unsigned MAX_WAYPOINTS = rpr_pkg::MAX_WAYPOINTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rpr_pkg::CNT_W-1:0]        i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [rpr_pkg::OP_W-1:0]         i_op,
    input  logic [rpr_pkg::DIST_W-1:0]       i_wp_distance,
    input  logic signed [rpr_pkg::ALT_W-1:0] i_wp_altitude,
    input  logic [rpr_pkg::CNT_W-1:0]        i_sample_index,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [rpr_pkg::DIST_W-1:0]       o_sample_distance,
    output logic signed [rpr_pkg::ALT_W-1:0] o_sample_altitude,
    output logic                             o_profile_valid,
    output logic                             o_route_overflow
);
    import rpr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rpr_dp #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_op              (i_op),
        .i_wp_distance     (i_wp_distance),
        .i_wp_altitude     (i_wp_altitude),
        .i_sample_index    (i_sample_index),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_sample_distance (o_sample_distance),
        .o_sample_altitude (o_sample_altitude),
        .o_profile_valid   (o_profile_valid),
        .o_route_overflow  (o_route_overflow)
    );

endmodule
